// ===== hw/rtl/hsc_pkg.sv =====
// ----------------------------------------------------------------------------
// hsc_pkg
// Shared types, constants and bit-level functions of the 13/8 SECDED codec.
// ----------------------------------------------------------------------------
package hsc_pkg;

  localparam int unsigned DATA_W   = 8;
  localparam int unsigned WORD_W   = 13;
  localparam int unsigned SYN_W    = 4;
  localparam logic [SYN_W-1:0] LAST_POS = 4'd12;

  localparam logic [SYN_W-1:0] DATA_POS [DATA_W] = '{
    4'd3, 4'd5, 4'd6, 4'd7, 4'd9, 4'd10, 4'd11, 4'd12
  };

  typedef enum logic {
    OP_ENCODE = 1'b0,
    OP_DECODE = 1'b1
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [SYN_W-1:0]  syn;
    logic [WORD_W-1:0] cw;
    logic [WORD_W-1:0] enc;
  } s1_t;

  typedef struct packed {
    op_t               op;
    logic              syn_bad;
    logic              rx_par;
    logic [DATA_W-1:0] data;
    logic [WORD_W-1:0] enc;
  } s2_t;

  function automatic logic [SYN_W-1:0] syndrome13(input logic [WORD_W-1:0] w);
    logic [SYN_W-1:0] syn;
    syn = '0;
    for (int j = 1; j < WORD_W; j++) begin
      if (w[j]) begin
        syn = syn ^ SYN_W'(j);
      end
    end
    return syn;
  endfunction

  function automatic logic [WORD_W-1:0] encode13(input logic [DATA_W-1:0] d);
    logic [WORD_W-1:0] w;
    logic [SYN_W-1:0]  syn;
    w = '0;
    for (int i = 0; i < DATA_W; i++) begin
      w[DATA_POS[i]] = d[i];
    end
    syn  = syndrome13(w);
    w[1] = syn[0];
    w[2] = syn[1];
    w[4] = syn[2];
    w[8] = syn[3];
    w[0] = ^w[WORD_W-1:1];
    return w;
  endfunction

  function automatic logic [DATA_W-1:0] extract13(input logic [WORD_W-1:0] w);
    logic [DATA_W-1:0] d;
    for (int i = 0; i < DATA_W; i++) begin
      d[i] = w[DATA_POS[i]];
    end
    return d;
  endfunction

endpackage

// ===== hw/rtl/hsc_stage1.sv =====
// ----------------------------------------------------------------------------
// hsc_stage1
// Input stage: encodes the data byte and computes the syndrome of the word.
// ----------------------------------------------------------------------------
module hsc_stage1 (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        valid_i,
  output logic                        ready_o,
  input  logic                        opcode_i,
  input  logic [hsc_pkg::DATA_W-1:0]  data_i,
  input  logic [hsc_pkg::WORD_W-1:0]  cw_i,
  output logic                        valid_o,
  input  logic                        ready_i,
  output hsc_pkg::s1_t                s1_o
);

  logic         valid_r;
  hsc_pkg::s1_t s1_r;
  hsc_pkg::s1_t s1_nxt;

  assign ready_o = !valid_r || ready_i;

  always_comb begin
    s1_nxt.op  = hsc_pkg::op_t'(opcode_i);
    s1_nxt.syn = hsc_pkg::syndrome13(cw_i);
    s1_nxt.cw  = cw_i;
    s1_nxt.enc = hsc_pkg::encode13(data_i);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_o) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && valid_i) begin
      s1_r <= s1_nxt;
    end
  end

  assign valid_o = valid_r;
  assign s1_o    = s1_r;

endmodule

// ===== hw/rtl/hsc_stage2.sv =====
// ----------------------------------------------------------------------------
// hsc_stage2
// Correction stage: flips the bit named by the syndrome and extracts the data.
// ----------------------------------------------------------------------------
module hsc_stage2 (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         valid_i,
  output logic         ready_o,
  input  hsc_pkg::s1_t s1_i,
  output logic         valid_o,
  input  logic         ready_i,
  output hsc_pkg::s2_t s2_o
);

  logic                       valid_r;
  hsc_pkg::s2_t               s2_r;
  hsc_pkg::s2_t               s2_nxt;
  logic [hsc_pkg::WORD_W-1:0] fixed;

  assign ready_o = !valid_r || ready_i;

  always_comb begin
    fixed = s1_i.cw;
    if ((s1_i.syn != '0) && (s1_i.syn <= hsc_pkg::LAST_POS)) begin
      fixed = s1_i.cw ^ (hsc_pkg::WORD_W'(1) << s1_i.syn);
    end
    s2_nxt.op      = s1_i.op;
    s2_nxt.syn_bad = s1_i.syn > hsc_pkg::LAST_POS;
    s2_nxt.rx_par  = fixed[0];
    s2_nxt.data    = hsc_pkg::extract13(fixed);
    s2_nxt.enc     = s1_i.enc;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_o) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && valid_i) begin
      s2_r <= s2_nxt;
    end
  end

  assign valid_o = valid_r;
  assign s2_o    = s2_r;

endmodule

// ===== hw/rtl/hsc_stage3.sv =====
// ----------------------------------------------------------------------------
// hsc_stage3
// Output stage: re-encodes the corrected data, checks parity, forms results.
// ----------------------------------------------------------------------------
module hsc_stage3 (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        valid_i,
  output logic                        ready_o,
  input  hsc_pkg::s2_t                s2_i,
  output logic                        valid_o,
  input  logic                        ready_i,
  output logic [hsc_pkg::WORD_W-1:0]  encoded_word_o,
  output logic [hsc_pkg::DATA_W-1:0]  decoded_byte_o,
  output logic                        uncorrectable_o
);

  logic                       valid_r;
  logic [hsc_pkg::WORD_W-1:0] enc_r;
  logic [hsc_pkg::WORD_W-1:0] enc_nxt;
  logic [hsc_pkg::DATA_W-1:0] dec_r;
  logic [hsc_pkg::DATA_W-1:0] dec_nxt;
  logic                       unc_r;
  logic                       unc_nxt;
  logic [hsc_pkg::WORD_W-1:0] fresh;
  logic                       bad;

  assign ready_o = !valid_r || ready_i;

  always_comb begin
    fresh   = hsc_pkg::encode13(s2_i.data);
    bad     = s2_i.syn_bad || (fresh[0] != s2_i.rx_par);
    enc_nxt = '0;
    dec_nxt = '0;
    unc_nxt = 1'b0;
    unique case (s2_i.op)
      hsc_pkg::OP_ENCODE: begin
        enc_nxt = s2_i.enc;
      end
      hsc_pkg::OP_DECODE: begin
        unc_nxt = bad;
        dec_nxt = bad ? '0 : s2_i.data;
      end
      default: begin
        enc_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_o) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && valid_i) begin
      enc_r <= enc_nxt;
      dec_r <= dec_nxt;
      unc_r <= unc_nxt;
    end
  end

  assign valid_o         = valid_r;
  assign encoded_word_o  = enc_r;
  assign decoded_byte_o  = dec_r;
  assign uncorrectable_o = unc_r;

endmodule

// ===== hw/rtl/hamming_secded_codec_13_8.sv =====
// ----------------------------------------------------------------------------
// hamming_secded_codec_13_8
// Three-stage pipelined Hamming SECDED encoder and decoder, 8 data bits in a
// 13-bit word with overall parity in bit 0.
//
//   Channel  Direction  Handshake              Payload
//   in       input      in_valid / in_ready    opcode, data_byte, code_word
//   out      output     out_valid / out_ready  encoded_word, decoded_byte,
//                                              uncorrectable
//
// One transaction is accepted per cycle while in_ready is high, which drops
// under back-pressure; each result passes through the three pipeline registers.
// Reset clears the stage valid bits only; the pipeline is empty afterwards.
// A stalled output holds its stage, and each earlier stage stalls only once
// the stage after it is full, so bubbles are filled while waiting.
// ----------------------------------------------------------------------------
module hamming_secded_codec_13_8 (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_opcode,
  input  logic [hsc_pkg::DATA_W-1:0]  in_data_byte,
  input  logic [hsc_pkg::WORD_W-1:0]  in_code_word,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [hsc_pkg::WORD_W-1:0]  out_encoded_word,
  output logic [hsc_pkg::DATA_W-1:0]  out_decoded_byte,
  output logic                        out_uncorrectable
);

  logic         s1_valid;
  logic         s2_ready;
  hsc_pkg::s1_t s1;
  logic         s2_valid;
  logic         s3_ready;
  hsc_pkg::s2_t s2;

  hsc_stage1 u_stage1 (
    .clk      (clk),
    .rst_n    (rst_n),
    .valid_i  (in_valid),
    .ready_o  (in_ready),
    .opcode_i (in_opcode),
    .data_i   (in_data_byte),
    .cw_i     (in_code_word),
    .valid_o  (s1_valid),
    .ready_i  (s2_ready),
    .s1_o     (s1)
  );

  hsc_stage2 u_stage2 (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (s1_valid),
    .ready_o (s2_ready),
    .s1_i    (s1),
    .valid_o (s2_valid),
    .ready_i (s3_ready),
    .s2_o    (s2)
  );

  hsc_stage3 u_stage3 (
    .clk             (clk),
    .rst_n           (rst_n),
    .valid_i         (s2_valid),
    .ready_o         (s3_ready),
    .s2_i            (s2),
    .valid_o         (out_valid),
    .ready_i         (out_ready),
    .encoded_word_o  (out_encoded_word),
    .decoded_byte_o  (out_decoded_byte),
    .uncorrectable_o (out_uncorrectable)
  );

endmodule

// ===== hw/rtl/hsc_checker.sv =====
// ----------------------------------------------------------------------------
// hsc_checker
// Port-level assertions on the codec's result channel, bound to the top level.
// ----------------------------------------------------------------------------
module hsc_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [hsc_pkg::WORD_W-1:0]  out_encoded_word,
  input logic [hsc_pkg::DATA_W-1:0]  out_decoded_byte,
  input logic                        out_uncorrectable
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_encoded_word)
      && $stable(out_decoded_byte) && $stable(out_uncorrectable))
    else $error("Stalled result transaction changed.");

  a_flag_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_uncorrectable |-> out_decoded_byte == '0)
    else $error("Flagged decode carries data.");

  a_flag_no_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_uncorrectable |-> out_encoded_word == '0)
    else $error("Flagged decode carries a code word.");

  a_enc_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_encoded_word != '0 |-> out_decoded_byte == '0)
    else $error("Encode result carries decoded data.");

endmodule

bind hamming_secded_codec_13_8 hsc_checker u_hsc_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_encoded_word  (out_encoded_word),
  .out_decoded_byte  (out_decoded_byte),
  .out_uncorrectable (out_uncorrectable)
);

// ===== test/hamming_secded_codec_13_8_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hamming_secded_codec_13_8_test
// Self-checking bench for the 13/8 SECDED codec. After a directed set of
// encode and decode transactions, random ones are sent in bursts while the
// result side stalls in shifting patterns. A scoreboard predicts every result
// and checks each one field by field.
// ----------------------------------------------------------------------------
class codec_scoreboard;

  typedef struct packed {
    logic [hsc_pkg::WORD_W-1:0] word;
    logic [hsc_pkg::DATA_W-1:0] data;
    logic                       flag;
  } codec_result_t;

  codec_result_t expected_q[$];
  int            errors;

  function new();
    errors = 0;
  endfunction

  function logic [hsc_pkg::WORD_W-1:0] hamming_word(input logic [hsc_pkg::DATA_W-1:0] d);
    logic [hsc_pkg::WORD_W-1:0] w;
    w[12] = d[7];
    w[11] = d[6];
    w[10] = d[5];
    w[9]  = d[4];
    w[8]  = d[4] ^ d[5] ^ d[6] ^ d[7];
    w[7]  = d[3];
    w[6]  = d[2];
    w[5]  = d[1];
    w[4]  = d[1] ^ d[2] ^ d[3] ^ d[7];
    w[3]  = d[0];
    w[2]  = d[0] ^ d[2] ^ d[3] ^ d[5] ^ d[6];
    w[1]  = d[0] ^ d[1] ^ d[3] ^ d[4] ^ d[6];
    w[0]  = ^w[hsc_pkg::WORD_W-1:1];
    return w;
  endfunction

  function codec_result_t predict(input hsc_pkg::op_t op,
                                  input logic [hsc_pkg::DATA_W-1:0] d,
                                  input logic [hsc_pkg::WORD_W-1:0] w);
    codec_result_t              r;
    logic [hsc_pkg::SYN_W-1:0]  syn;
    logic [hsc_pkg::WORD_W-1:0] fixed;
    logic [hsc_pkg::WORD_W-1:0] fresh;
    logic [hsc_pkg::DATA_W-1:0] got;
    r = '0;
    if (op == hsc_pkg::OP_ENCODE) begin
      r.word = hamming_word(d);
      return r;
    end
    syn = '0;
    for (int p = 1; p < hsc_pkg::WORD_W; p++) begin
      if (w[p]) begin
        syn = syn ^ hsc_pkg::SYN_W'(p);
      end
    end
    if (syn > hsc_pkg::LAST_POS) begin
      r.flag = 1'b1;
      return r;
    end
    fixed = w;
    if (syn != 0) begin
      fixed[syn] = ~fixed[syn];
    end
    got   = {fixed[12:9], fixed[7:5], fixed[3]};
    fresh = hamming_word(got);
    if (fresh[0] != w[0]) begin
      r.flag = 1'b1;
    end else begin
      r.data = got;
    end
    return r;
  endfunction

  function void note_input(input hsc_pkg::op_t op,
                           input logic [hsc_pkg::DATA_W-1:0] d,
                           input logic [hsc_pkg::WORD_W-1:0] w);
    expected_q.push_back(predict(op, d, w));
  endfunction

  function int pending();
    return expected_q.size();
  endfunction

  task report(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    errors++;
  endtask

  task check(input logic [hsc_pkg::WORD_W-1:0] word,
             input logic [hsc_pkg::DATA_W-1:0] data,
             input logic flag);
    codec_result_t e;
    if (expected_q.size() == 0) begin
      report($sformatf("unexpected result word=%h data=%h flag=%b", word, data, flag));
      return;
    end
    e = expected_q.pop_front();
    if (word !== e.word) begin
      report($sformatf("encoded_word %h, expected %h", word, e.word));
    end
    if (data !== e.data) begin
      report($sformatf("decoded_byte %h, expected %h", data, e.data));
    end
    if (flag !== e.flag) begin
      report($sformatf("uncorrectable %b, expected %b", flag, e.flag));
    end
  endtask

endclass

module hamming_secded_codec_13_8_test;

  localparam int RANDOM_ITEMS   = 1550;
  localparam int DRAIN_EVERY    = 500;
  localparam int WATCHDOG_LIMIT = 5000;

  typedef enum int {RX_ALWAYS, RX_RANDOM, RX_PERIODIC, RX_RUNS} rx_mode_t;

  logic                       clk;
  logic                       rst_n;
  logic                       in_valid;
  logic                       in_ready;
  logic                       in_opcode;
  logic [hsc_pkg::DATA_W-1:0] in_data_byte;
  logic [hsc_pkg::WORD_W-1:0] in_code_word;
  logic                       out_valid;
  logic                       out_ready;
  logic [hsc_pkg::WORD_W-1:0] out_encoded_word;
  logic [hsc_pkg::DATA_W-1:0] out_decoded_byte;
  logic                       out_uncorrectable;

  codec_scoreboard sb = new();

  hamming_secded_codec_13_8 dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_opcode         (in_opcode),
    .in_data_byte      (in_data_byte),
    .in_code_word      (in_code_word),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_encoded_word  (out_encoded_word),
    .out_decoded_byte  (out_decoded_byte),
    .out_uncorrectable (out_uncorrectable)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  task automatic send(input hsc_pkg::op_t op, input logic [hsc_pkg::DATA_W-1:0] d,
                      input logic [hsc_pkg::WORD_W-1:0] w);
    in_valid     <= 1'b1;
    in_opcode    <= op;
    in_data_byte <= d;
    in_code_word <= w;
    do @(posedge clk); while (!in_ready);
    sb.note_input(op, d, w);
  endtask

  task automatic pause(input int cycles);
    if (cycles > 0) begin
      in_valid <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic send_random();
    logic [hsc_pkg::DATA_W-1:0] d;
    logic [hsc_pkg::WORD_W-1:0] w;
    int                         kind;
    int                         a;
    int                         b;
    d    = hsc_pkg::DATA_W'($urandom);
    w    = sb.hamming_word(hsc_pkg::DATA_W'($urandom));
    kind = $urandom_range(0, 99);
    a    = $urandom_range(0, hsc_pkg::WORD_W - 1);
    b    = (a + $urandom_range(1, hsc_pkg::WORD_W - 1)) % hsc_pkg::WORD_W;
    if (kind < 30) begin
      send(hsc_pkg::OP_ENCODE, d, hsc_pkg::WORD_W'($urandom));
    end else if (kind < 48) begin
      send(hsc_pkg::OP_DECODE, d, w);
    end else if (kind < 73) begin
      send(hsc_pkg::OP_DECODE, d, w ^ (hsc_pkg::WORD_W'(1) << a));
    end else if (kind < 90) begin
      send(hsc_pkg::OP_DECODE, d,
           w ^ (hsc_pkg::WORD_W'(1) << a) ^ (hsc_pkg::WORD_W'(1) << b));
    end else begin
      send(hsc_pkg::OP_DECODE, d, hsc_pkg::WORD_W'($urandom));
    end
  endtask

  // Result side: checks every accepted transaction and varies its stall
  // pattern every so often, including long runs of back-pressure.
  initial begin
    rx_mode_t mode;
    int       cyc;
    int       hold;
    logic     level;
    mode      = RX_ALWAYS;
    cyc       = 0;
    hold      = 0;
    level     = 1'b1;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        sb.check(out_encoded_word, out_decoded_byte, out_uncorrectable);
      end
      cyc++;
      if (cyc % 96 == 0) begin
        mode = rx_mode_t'($urandom_range(0, 3));
      end
      case (mode)
        RX_ALWAYS: begin
          out_ready <= 1'b1;
        end
        RX_RANDOM: begin
          out_ready <= ($urandom_range(0, 2) != 0);
        end
        RX_PERIODIC: begin
          out_ready <= (cyc % 7 >= 3);
        end
        default: begin
          if (hold == 0) begin
            hold  = $urandom_range(1, 15);
            level = ~level;
          end
          hold--;
          out_ready <= level;
        end
      endcase
    end
  end

  initial begin
    int idle;
    idle = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle = 0;
      end else begin
        idle++;
      end
      if (idle >= WATCHDOG_LIMIT) begin
        $display("[hamming_secded_codec_13_8] ERROR");
        $finish;
      end
    end
  end

  initial begin
    logic [hsc_pkg::WORD_W-1:0] clean;
    int                         sent;
    int                         burst;
    int                         next_drain;
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_opcode    <= hsc_pkg::OP_ENCODE;
    in_data_byte <= '0;
    in_code_word <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send(hsc_pkg::OP_ENCODE, 8'h00, 13'h1FFF);
    send(hsc_pkg::OP_ENCODE, 8'hFF, 13'h0000);
    send(hsc_pkg::OP_ENCODE, 8'hA5, 13'h0AAA);
    clean = sb.hamming_word(8'h3C);
    send(hsc_pkg::OP_DECODE, 8'hFF, clean);
    for (int k = 0; k < hsc_pkg::WORD_W; k++) begin
      send(hsc_pkg::OP_DECODE, 8'h00, clean ^ (hsc_pkg::WORD_W'(1) << k));
    end
    send(hsc_pkg::OP_DECODE, 8'h5A, sb.hamming_word(8'hC3) ^ 13'h0024);
    send(hsc_pkg::OP_DECODE, 8'h00, 13'h1FFF);
    send(hsc_pkg::OP_DECODE, 8'hFF, 13'h0000);
    send(hsc_pkg::OP_DECODE, 8'h81, 13'h0112);
    drain();

    sent       = 0;
    next_drain = DRAIN_EVERY;
    while (sent < RANDOM_ITEMS) begin
      burst = $urandom_range(1, 40);
      for (int k = 0; k < burst; k++) begin
        send_random();
        sent++;
      end
      if (sent >= next_drain) begin
        drain();
        next_drain += DRAIN_EVERY;
      end else if ($urandom_range(0, 3) != 0) begin
        pause($urandom_range(1, 6));
      end
    end

    drain();
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("[hamming_secded_codec_13_8] OK");
    end else begin
      $display("[hamming_secded_codec_13_8] ERROR");
    end
    $finish;
  end

endmodule
